// ===== sv/maxlog_soft_demapper_top_defines.svh =====
// Assertion macros for the max-log soft demapper.
`ifndef MAXLOG_SOFT_DEMAPPER_TOP_DEFINES_SVH
`define MAXLOG_SOFT_DEMAPPER_TOP_DEFINES_SVH
`ifndef SYNTHESIS
// same-cycle implication
`define MSD_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("msd: same-cycle check failed");
// next-cycle implication
`define MSD_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("msd: next-cycle check failed");
`else
`define MSD_ASSERT_IMPL(lbl, clk, rst_n, ante, cons)
`define MSD_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

// ===== sv/msd_pkg.sv =====
// Types and constants shared by the max-log soft demapper.
package msd_pkg;

    // configuration port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;
    localparam int CFG_BPS_W  = 3;
    localparam int CFG_PTS_W  = 7;
    localparam int CFG_INV_W  = 16;

    localparam logic [CFG_BPS_W-1:0] BPS_RESET = 3'd2;
    localparam logic [CFG_PTS_W-1:0] PTS_RESET = 7'd4;
    localparam logic [CFG_INV_W-1:0] INV_RESET = 16'd256;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_BITS_PER_SYMBOL = 2'd0,
        CFG_POINTS_IN_USE   = 2'd1,
        CFG_INV_NOISE_VAR   = 2'd2
    } t_cfg_idx;

    // word kinds on the input channel
    localparam logic KIND_LOAD  = 1'b0;
    localparam logic KIND_DEMAP = 1'b1;

    // result format
    localparam int LLR_W     = 16;
    localparam int POS_W     = 3;
    localparam int OUT_W     = 24;
    localparam int INV_FRAC  = 8;
    // distance difference clamped to this signed width before scaling;
    // anything wider saturates the LLR anyway
    localparam int CLAMP_W   = 25;
    localparam int PROD_W    = CLAMP_W + CFG_INV_W + 1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN,
        ST_DIFF,
        ST_MUL,
        ST_EMIT
    } t_state;

endpackage

// ===== sv/maxlog_soft_demapper_top.sv =====
// Max-log soft demapper: point table, scan pipeline and LLR scaler.
//
// Input channel (i_s_*): one word either loads a constellation point into
// the table (tuser = 0) or demaps a received sample (tuser = 1); tlast marks
// the last symbol of a block. A load gives no result.
// A demap scans the first points_in_use table slots through one shared
// distance pipeline, one point per cycle, then runs each bit position
// through one shared subtract/multiply/saturate unit and emits one LLR word
// per bit on the output channel (o_m_*), bit 0 first, tlast on the last bit,
// tuser carrying the block end flag of the symbol.
// The scan loop feeds the points through the distance pipeline, which drains
// before the scaler takes each bit through its difference, multiply and emit
// states. The input is not ready while a symbol is in work; the block is
// ready again while the last LLR still waits in the output register. A
// stalled receiver holds the output register and the scaler waits for it.
// Reset (synchronous, active low) returns the registers to 2, 4 and 256 and
// empties the pipeline; the point table is not cleared and must be loaded
// before use. Configuration is to be written by the user only while the
// block is idle; the block itself does not enforce this.
`include "maxlog_soft_demapper_top_defines.svh"

module maxlog_soft_demapper_top #(
    parameter int MAX_POINTS   = 64,
    parameter int MAX_BITS     = 6,
    parameter int SAMPLE_WIDTH = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // configuration
    input  logic                          i_cfg_we,
    input  logic [msd_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [msd_pkg::CFG_DATA_W-1:0] i_cfg_data,
    // input words
    input  logic                          i_s_tvalid,
    output logic                          o_s_tready,
    // point_index, point_i, point_q, point_label, rx_i, rx_q, zero pad
    input  logic [((($clog2(MAX_POINTS) + 4 * SAMPLE_WIDTH + MAX_BITS) + 7) / 8) * 8 - 1:0]
                                          i_s_tdata,
    input  logic                          i_s_tuser,   // kind
    input  logic                          i_s_tlast,   // block_end
    // result words
    output logic                          o_m_tvalid,
    input  logic                          i_m_tready,
    output logic [msd_pkg::OUT_W-1:0]     o_m_tdata,   // llr, bit_position, zero pad
    output logic                          o_m_tuser,   // block_end_out
    output logic                          o_m_tlast    // last_of_symbol
);

    localparam int SW     = SAMPLE_WIDTH;
    localparam int PIDX_W = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
    localparam int CNT_W  = PIDX_W + 1;
    localparam int DIST_W = 2 * SW + 2;
    localparam int EXT_W  = (DIST_W + 1 > msd_pkg::CLAMP_W) ? DIST_W + 1 : msd_pkg::CLAMP_W;
    localparam int NPW    = (CNT_W > msd_pkg::CFG_PTS_W) ? CNT_W : msd_pkg::CFG_PTS_W;
    localparam int BIDX_W = (MAX_BITS > 1) ? $clog2(MAX_BITS) : 1;
    localparam int ENT_W  = 2 * SW + MAX_BITS;

    // input field offsets
    localparam int OFS_PI  = PIDX_W;
    localparam int OFS_PQ  = OFS_PI + SW;
    localparam int OFS_LAB = OFS_PQ + SW;
    localparam int OFS_RI  = OFS_LAB + MAX_BITS;
    localparam int OFS_RQ  = OFS_RI + SW;

    localparam logic signed [msd_pkg::CLAMP_W-1:0] CLAMP_MAX =
        {1'b0, {(msd_pkg::CLAMP_W-1){1'b1}}};
    localparam logic signed [msd_pkg::CLAMP_W-1:0] CLAMP_MIN =
        {1'b1, {(msd_pkg::CLAMP_W-1){1'b0}}};
    localparam logic signed [msd_pkg::LLR_W-1:0] LLR_MAX =
        {1'b0, {(msd_pkg::LLR_W-1){1'b1}}};
    localparam logic signed [msd_pkg::LLR_W-1:0] LLR_MIN =
        {1'b1, {(msd_pkg::LLR_W-1){1'b0}}};

    // input field views
    logic [PIDX_W-1:0]   s_in_idx;
    logic [SW-1:0]       s_in_pi;
    logic [SW-1:0]       s_in_pq;
    logic [MAX_BITS-1:0] s_in_lab;
    logic [SW-1:0]       s_in_ri;
    logic [SW-1:0]       s_in_rq;

    assign s_in_idx = i_s_tdata[PIDX_W-1:0];
    assign s_in_pi  = i_s_tdata[OFS_PI +: SW];
    assign s_in_pq  = i_s_tdata[OFS_PQ +: SW];
    assign s_in_lab = i_s_tdata[OFS_LAB +: MAX_BITS];
    assign s_in_ri  = i_s_tdata[OFS_RI +: SW];
    assign s_in_rq  = i_s_tdata[OFS_RQ +: SW];

    // configuration registers
    logic [msd_pkg::CFG_BPS_W-1:0] r_cfg_bps;
    logic [msd_pkg::CFG_PTS_W-1:0] r_cfg_pts;
    logic [msd_pkg::CFG_INV_W-1:0] r_cfg_inv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_bps <= msd_pkg::BPS_RESET;
            r_cfg_pts <= msd_pkg::PTS_RESET;
            r_cfg_inv <= msd_pkg::INV_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                msd_pkg::CFG_BITS_PER_SYMBOL: r_cfg_bps <= i_cfg_data[msd_pkg::CFG_BPS_W-1:0];
                msd_pkg::CFG_POINTS_IN_USE:   r_cfg_pts <= i_cfg_data[msd_pkg::CFG_PTS_W-1:0];
                msd_pkg::CFG_INV_NOISE_VAR:   r_cfg_inv <= i_cfg_data[msd_pkg::CFG_INV_W-1:0];
                default: ;
            endcase
        end
    end

    // state and control
    msd_pkg::t_state r_state, n_state;

    logic s_in_acc;
    logic s_load;
    logic s_demap;
    logic s_scan_more;
    logic s_issue;
    logic s_pipe_busy;
    logic s_emit;
    logic s_last_bit;

    logic [CNT_W-1:0]               r_scan;
    logic [CNT_W-1:0]               r_npts;
    logic [msd_pkg::CFG_BPS_W-1:0]  r_nbits;
    logic [msd_pkg::CFG_INV_W-1:0]  r_inv;
    logic [msd_pkg::POS_W-1:0]      r_bit;
    logic                           r_bend;
    logic [SW-1:0]                  r_rx_i;
    logic [SW-1:0]                  r_rx_q;

    logic r_p1_vld, r_p2_vld, r_p3_vld, r_p4_vld;

    assign s_in_acc    = i_s_tvalid && o_s_tready;
    assign s_load      = s_in_acc && (i_s_tuser == msd_pkg::KIND_LOAD);
    assign s_demap     = s_in_acc && (i_s_tuser == msd_pkg::KIND_DEMAP);
    assign s_scan_more = (r_scan < r_npts);
    assign s_pipe_busy = r_p1_vld || r_p2_vld || r_p3_vld || r_p4_vld;
    assign s_last_bit  = ({1'b0, r_bit} == {1'b0, r_nbits} - 4'd1);

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            msd_pkg::ST_IDLE: begin
                if (s_demap) n_state = msd_pkg::ST_SCAN;
            end
            msd_pkg::ST_SCAN: begin
                if (!s_scan_more) n_state = msd_pkg::ST_DRAIN;
            end
            msd_pkg::ST_DRAIN: begin
                if (!s_pipe_busy) begin
                    n_state = (r_nbits == '0) ? msd_pkg::ST_IDLE : msd_pkg::ST_DIFF;
                end
            end
            msd_pkg::ST_DIFF: n_state = msd_pkg::ST_MUL;
            msd_pkg::ST_MUL:  n_state = msd_pkg::ST_EMIT;
            msd_pkg::ST_EMIT: begin
                if (s_emit) n_state = s_last_bit ? msd_pkg::ST_IDLE : msd_pkg::ST_DIFF;
            end
            default: n_state = msd_pkg::ST_IDLE;
        endcase
    end

    // state outputs
    always_comb begin
        o_s_tready = 1'b0;
        s_issue    = 1'b0;
        s_emit     = 1'b0;
        unique case (r_state)
            msd_pkg::ST_IDLE: o_s_tready = 1'b1;
            msd_pkg::ST_SCAN: s_issue    = s_scan_more;
            msd_pkg::ST_EMIT: s_emit     = !o_m_tvalid || i_m_tready;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= msd_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // symbol set-up: limits, scale and sample latched at the demap word
    logic [NPW-1:0]                s_pts_ext;
    logic [NPW-1:0]                s_npts;
    logic [msd_pkg::CFG_BPS_W-1:0] s_nbits;

    assign s_pts_ext = NPW'(r_cfg_pts);
    assign s_npts    = (s_pts_ext > NPW'(MAX_POINTS)) ? NPW'(MAX_POINTS) : s_pts_ext;
    assign s_nbits   = ({1'b0, r_cfg_bps} > 4'(MAX_BITS)) ?
                       msd_pkg::CFG_BPS_W'(MAX_BITS) : r_cfg_bps;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scan  <= '0;
            r_npts  <= '0;
            r_nbits <= '0;
            r_bit   <= '0;
        end else begin
            if (s_demap) begin
                r_scan  <= '0;
                r_npts  <= s_npts[CNT_W-1:0];
                r_nbits <= s_nbits;
            end else if (s_issue) begin
                r_scan  <= r_scan + 1'b1;
            end
            // bit counter for the scaler
            if (r_state == msd_pkg::ST_DRAIN) begin
                r_bit <= '0;
            end else if (s_emit) begin
                r_bit <= r_bit + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_demap) begin
            r_rx_i <= s_in_ri;
            r_rx_q <= s_in_rq;
            r_bend <= i_s_tlast;
            r_inv  <= r_cfg_inv;
        end
    end

    // point table: label, Q, I in one entry
    logic [ENT_W-1:0] r_mem [MAX_POINTS];
    logic [ENT_W-1:0] r_rd;

    always_ff @(posedge i_clk) begin
        if (s_load) begin
            r_mem[s_in_idx] <= {s_in_lab, s_in_pq, s_in_pi};
        end
        if (s_issue) begin
            r_rd <= r_mem[r_scan[PIDX_W-1:0]];
        end
    end

    // distance pipeline: read, difference, square, sum
    logic signed [SW:0]     r_di, r_dq;
    logic [MAX_BITS-1:0]    r_lab2, r_lab3, r_lab4;
    logic signed [DIST_W-1:0] s_sq_i, s_sq_q;
    logic [DIST_W-1:0]      r_sq_i, r_sq_q;
    logic [DIST_W-1:0]      r_dist;

    assign s_sq_i = DIST_W'(r_di) * DIST_W'(r_di);
    assign s_sq_q = DIST_W'(r_dq) * DIST_W'(r_dq);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p1_vld <= 1'b0;
            r_p2_vld <= 1'b0;
            r_p3_vld <= 1'b0;
            r_p4_vld <= 1'b0;
        end else begin
            r_p1_vld <= s_issue;
            r_p2_vld <= r_p1_vld;
            r_p3_vld <= r_p2_vld;
            r_p4_vld <= r_p3_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_di   <= $signed({r_rx_i[SW-1], r_rx_i}) - $signed({r_rd[SW-1], r_rd[SW-1:0]});
        r_dq   <= $signed({r_rx_q[SW-1], r_rx_q}) - $signed({r_rd[2*SW-1], r_rd[2*SW-1:SW]});
        r_lab2 <= r_rd[ENT_W-1:2*SW];
        r_sq_i <= $unsigned(s_sq_i);
        r_sq_q <= $unsigned(s_sq_q);
        r_lab3 <= r_lab2;
        r_dist <= r_sq_i + r_sq_q;
        r_lab4 <= r_lab3;
    end

    // running minima per bit and label value
    logic [DIST_W-1:0] r_min0 [MAX_BITS];
    logic [DIST_W-1:0] r_min1 [MAX_BITS];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int b = 0; b < MAX_BITS; b++) begin
                r_min0[b] <= '1;
                r_min1[b] <= '1;
            end
        end else if (s_demap) begin
            for (int b = 0; b < MAX_BITS; b++) begin
                r_min0[b] <= '1;
                r_min1[b] <= '1;
            end
        end else if (r_p4_vld) begin
            for (int b = 0; b < MAX_BITS; b++) begin
                if (r_lab4[b]) begin
                    if (r_dist < r_min1[b]) r_min1[b] <= r_dist;
                end else begin
                    if (r_dist < r_min0[b]) r_min0[b] <= r_dist;
                end
            end
        end
    end

    // scaler stage 1: difference of minima, clamped
    logic [EXT_W-1:0]                     s_z0, s_z1;
    logic signed [EXT_W-1:0]              s_diff;
    logic                                 s_diff_ovf;
    logic signed [msd_pkg::CLAMP_W-1:0]   r_cdiff;

    assign s_z0       = EXT_W'(r_min0[r_bit[BIDX_W-1:0]]);
    assign s_z1       = EXT_W'(r_min1[r_bit[BIDX_W-1:0]]);
    assign s_diff     = $signed(s_z0 - s_z1);
    assign s_diff_ovf = (s_diff[EXT_W-1:msd_pkg::CLAMP_W-1] != '0) &&
                        (s_diff[EXT_W-1:msd_pkg::CLAMP_W-1] != '1);

    // scaler stage 2: multiply by inverse noise variance
    logic signed [msd_pkg::PROD_W-1:0] s_prod;
    logic signed [msd_pkg::PROD_W-1:0] r_prod;

    assign s_prod = msd_pkg::PROD_W'(r_cdiff) * msd_pkg::PROD_W'($signed({1'b0, r_inv}));

    always_ff @(posedge i_clk) begin
        if (r_state == msd_pkg::ST_DIFF) begin
            if (s_diff_ovf) begin
                r_cdiff <= s_diff[EXT_W-1] ? CLAMP_MIN : CLAMP_MAX;
            end else begin
                r_cdiff <= s_diff[msd_pkg::CLAMP_W-1:0];
            end
        end
        if (r_state == msd_pkg::ST_MUL) begin
            r_prod <= s_prod;
        end
    end

    // scaler stage 3: floor shift and saturate
    logic signed [msd_pkg::PROD_W-1:0] s_shr;
    logic                              s_sat;
    logic signed [msd_pkg::LLR_W-1:0]  s_llr;

    assign s_shr = r_prod >>> msd_pkg::INV_FRAC;
    assign s_sat = (s_shr[msd_pkg::PROD_W-1:msd_pkg::LLR_W-1] != '0) &&
                   (s_shr[msd_pkg::PROD_W-1:msd_pkg::LLR_W-1] != '1);
    assign s_llr = s_sat ? (s_shr[msd_pkg::PROD_W-1] ? LLR_MIN : LLR_MAX)
                         : s_shr[msd_pkg::LLR_W-1:0];

    // output register
    logic                             r_out_vld;
    logic [msd_pkg::LLR_W-1:0]        r_out_llr;
    logic [msd_pkg::POS_W-1:0]        r_out_pos;
    logic                             r_out_last;
    logic                             r_out_bend;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (s_emit) begin
            r_out_vld <= 1'b1;
        end else if (i_m_tready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_emit) begin
            r_out_llr  <= s_llr;
            r_out_pos  <= r_bit;
            r_out_last <= s_last_bit;
            r_out_bend <= r_bend;
        end
    end

    assign o_m_tvalid = r_out_vld;
    assign o_m_tdata  = {{(msd_pkg::OUT_W - msd_pkg::LLR_W - msd_pkg::POS_W){1'b0}},
                         r_out_pos, r_out_llr};
    assign o_m_tuser  = r_out_bend;
    assign o_m_tlast  = r_out_last;

    // checks
    `MSD_ASSERT_IMPL(a_idle_pipe_empty, i_clk, i_rst_n, o_s_tready, !s_pipe_busy)
    `MSD_ASSERT_NEXT(a_emit_fills_out, i_clk, i_rst_n, s_emit, o_m_tvalid)
    `MSD_ASSERT_IMPL(a_bit_in_range, i_clk, i_rst_n, (r_state == msd_pkg::ST_EMIT), (r_bit < r_nbits))

endmodule
